FILE: hdl/neighbor_count_3x3_defines.svh
`ifndef NEIGHBOR_COUNT_3X3_DEFINES_SVH
`define NEIGHBOR_COUNT_3X3_DEFINES_SVH

// same-cycle implication, disabled in reset
`define NCNT_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define NCNT_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ncnt_pkg.sv
`timescale 1ns / 1ps

package ncnt_pkg;

  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 64;

  localparam int CFG_W   = 7;
  localparam int CNT_W   = 4;
  localparam int POS_W   = 6;
  localparam int OQ_DEPTH = 3;

  localparam logic [CFG_W-1:0] GRID_DIM_RST = 7'd6;

  typedef enum logic {
    REG_GRID_ROWS = 1'b0,
    REG_GRID_COLS = 1'b1
  } ncnt_reg_t;

  typedef struct packed {
    logic             emit;
    logic             last;
    logic             bit_in;
    logic             use_old;
    logic             k0_en;
    logic             k2_en;
    logic             top_en;
    logic             bot_en;
    logic [POS_W-1:0] rq;
    logic [POS_W-1:0] cq;
  } ncnt_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } ncnt_res_t;

endpackage

FILE: hdl/ncnt_ram.sv
`timescale 1ns / 1ps

module ncnt_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/ncnt_front.sv
`timescale 1ns / 1ps

module ncnt_front #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ncnt_pkg::CFG_W-1:0]    grid_rows,
  input  logic [ncnt_pkg::CFG_W-1:0]    grid_cols,
  input  logic                          accept,
  input  logic                          in_mode,
  input  logic                          in_mine,
  output logic                          rd_go,
  output logic [$clog2(MAX_COLS)-1:0]   rd_addr,
  output logic                          upd_r,
  output logic [$clog2(MAX_COLS)-1:0]   addr_r,
  output ncnt_pkg::ncnt_ctl_t           ctl_r
);

  import ncnt_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS + 3);

  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic          done_r, done_nxt;

  logic [RW-1:0] rows_c, rows_p1, row0, row1, rq_full;
  logic [CW:0]   w_c, cq_full;
  logic [CW-1:0] col0, col1;
  logic          skip, over, fin, act;
  ncnt_ctl_t     ctl;

  always_comb begin
    if (grid_rows == '0) begin
      rows_c = RW'(1);
    end else if (32'(grid_rows) > MAX_ROWS) begin
      rows_c = RW'(MAX_ROWS);
    end else begin
      rows_c = RW'(grid_rows);
    end
    if (grid_cols == '0) begin
      w_c = (CW+1)'(1);
    end else if (32'(grid_cols) > MAX_COLS) begin
      w_c = (CW+1)'(MAX_COLS);
    end else begin
      w_c = (CW+1)'(grid_cols);
    end
  end

  assign rows_p1 = rows_c + RW'(1);

  always_comb begin
    row0 = done_r ? '0 : row_r;
    col0 = done_r ? '0 : col_r;
    if ({1'b0, col0} >= w_c) begin
      col1 = '0;
      row1 = (row0 == '1) ? row0 : row0 + RW'(1);
    end else begin
      col1 = col0;
      row1 = row0;
    end
  end

  assign skip = done_r && in_mode;
  assign act  = accept && !skip;
  assign over = (row1 > rows_p1) || ((row1 == rows_p1) && (col1 != '0));
  assign fin  = (row1 == rows_p1) && (col1 == '0);

  assign rq_full = (col1 != '0) ? row1 - RW'(1) : row1 - RW'(2);
  assign cq_full = (col1 != '0) ? {1'b0, col1} - (CW+1)'(1) : w_c - (CW+1)'(1);

  always_comb begin
    ctl.emit    = !((row1 == '0) || ((row1 == RW'(1)) && (col1 == '0)));
    ctl.last    = fin;
    ctl.bit_in  = !in_mode && (row1 < rows_c) && in_mine;
    ctl.use_old = (col1 == '0);
    ctl.k0_en   = (cq_full != (w_c - (CW+1)'(1)));
    ctl.k2_en   = (cq_full != '0);
    ctl.top_en  = (rq_full != '0);
    ctl.bot_en  = (({1'b0, rq_full} + (RW+1)'(1)) < {1'b0, rows_c});
    ctl.rq      = POS_W'(rq_full);
    ctl.cq      = POS_W'(cq_full);
  end

  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    done_nxt = done_r;
    if (act) begin
      if (over || fin) begin
        done_nxt = 1'b1;
        row_nxt  = row1;
        col_nxt  = col1;
      end else begin
        done_nxt = 1'b0;
        if (({1'b0, col1} + (CW+1)'(1)) >= w_c) begin
          col_nxt = '0;
          row_nxt = (row1 == '1) ? row1 : row1 + RW'(1);
        end else begin
          col_nxt = col1 + CW'(1);
          row_nxt = row1;
        end
      end
    end
  end

  assign rd_go   = act && !over;
  assign rd_addr = col1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      done_r <= 1'b0;
      upd_r  <= 1'b0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      done_r <= done_nxt;
      upd_r  <= rd_go;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_go) begin
      ctl_r  <= ctl;
      addr_r <= col1;
    end
  end

endmodule

FILE: hdl/ncnt_window.sv
`timescale 1ns / 1ps

module ncnt_window #(
  parameter int MAX_COLS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        upd,
  input  logic [$clog2(MAX_COLS)-1:0] addr,
  input  ncnt_pkg::ncnt_ctl_t         ctl,
  input  logic                        rd_go,
  input  logic [$clog2(MAX_COLS)-1:0] rd_addr,
  input  logic [1:0]                  rdata,
  output logic                        we_o,
  output logic [1:0]                  wdata,
  output logic                        push,
  output ncnt_pkg::ncnt_res_t         res
);

  import ncnt_pkg::*;

  `include "neighbor_count_3x3_defines.svh"

  logic [8:0]       win_r, win_nxt, src;
  logic             fwd_v_r;
  logic [1:0]       fwd_d_r;
  logic [1:0]       line;
  logic [2:0]       colv;
  logic [CNT_W-1:0] count;

  // bit 1 older row, bit 0 recent row
  assign line    = fwd_v_r ? fwd_d_r : rdata;
  assign colv    = {ctl.bit_in, line[0], line[1]};
  assign wdata   = {line[0], ctl.bit_in};
  assign we_o    = upd;
  assign win_nxt = {win_r[5:0], colv};
  assign src     = ctl.use_old ? {win_r[5:0], 3'b000} : win_nxt;

  always_comb begin
    logic [2:0] en;
    en    = {ctl.k2_en, 1'b1, ctl.k0_en};
    count = '0;
    for (int k = 0; k < 3; k++) begin
      if (en[k]) begin
        count = count + CNT_W'(src[3*k] & ctl.top_en) + CNT_W'(src[3*k+1])
              + CNT_W'(src[3*k+2] & ctl.bot_en);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      fwd_v_r <= 1'b0;
    end else begin
      if (upd) begin
        win_r <= win_nxt;
      end
      fwd_v_r <= upd && rd_go && (addr == rd_addr);
    end
  end

  // a read issued while this entry is being written gets the new word through this register
  always_ff @(posedge clk) begin
    fwd_d_r <= wdata;
  end

  assign push      = upd && ctl.emit;
  assign res.count = count;
  assign res.row   = ctl.rq;
  assign res.col   = ctl.cq;
  assign res.last  = ctl.last;

  `NCNT_AST_IMP(a_fwd_after_wr, fwd_v_r, $past(we_o) && $past(rd_go), "forward without write")
  `NCNT_AST_NXT(a_win_hold, !upd, $stable(win_r), "window moved without beat")
  `NCNT_AST_IMP(a_last_emits, upd && ctl.last, push, "last beat not emitted")

endmodule

FILE: hdl/ncnt_outq.sv
`timescale 1ns / 1ps

module ncnt_outq (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    push,
  input  ncnt_pkg::ncnt_res_t                     push_res,
  input  logic                                    out_tready,
  output logic                                    out_tvalid,
  output ncnt_pkg::ncnt_res_t                     out_res,
  output logic [$clog2(ncnt_pkg::OQ_DEPTH+1)-1:0] fill
);

  import ncnt_pkg::*;

  `include "neighbor_count_3x3_defines.svh"

  localparam int PW = $clog2(OQ_DEPTH);
  localparam int FW = $clog2(OQ_DEPTH + 1);

  ncnt_res_t     ent [OQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FW-1:0] fill_r;
  logic          pop;

  assign out_tvalid = (fill_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign out_res    = ent[rd_ptr_r];
  assign fill       = fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(OQ_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(OQ_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + FW'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr_r] <= push_res;
    end
  end

  `NCNT_AST_IMP(a_no_ovf, push && !pop, fill_r < FW'(OQ_DEPTH), "result queue overflow")
  `NCNT_AST_NXT(a_fill_dec, pop && !push, fill_r == $past(fill_r) - FW'(1), "fill count off")

endmodule

FILE: hdl/neighbor_count_3x3.sv
// path: a beat's control is registered in the front end, its result in the queue
// throughput: one input beat per cycle while the queue has room; each beat not past the
//   grid end does one read and one write of the two-row line store (one 2-bit word per column)
// reset: synchronous, active low; clears position, window and result queue,
//   grid_rows and grid_cols go to 6; the line store is not cleared
`timescale 1ns / 1ps

module neighbor_count_3x3 #(
  parameter int MAX_COLS = ncnt_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = ncnt_pkg::MAX_ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  ncnt_pkg::ncnt_reg_t        cfg_addr,
  input  logic [ncnt_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // mine
  input  logic                       in_tuser,   // mode
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [15:0]                out_tdata,  // count, out_row, out_col
  output logic                       out_tlast
);

  import ncnt_pkg::*;

  `include "neighbor_count_3x3_defines.svh"

  localparam int CW = $clog2(MAX_COLS);
  localparam int FW = $clog2(OQ_DEPTH + 1);

  logic [CFG_W-1:0] grid_rows_r, grid_cols_r;
  logic             accept, rd_go, upd, we, push, pend;
  logic [CW-1:0]    rd_addr, addr;
  logic [1:0]       rdata, wdata;
  logic [FW-1:0]    fill;
  logic [FW:0]      room_sum;
  ncnt_ctl_t        ctl;
  ncnt_res_t        push_res, out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= GRID_DIM_RST;
      grid_cols_r <= GRID_DIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GRID_ROWS: grid_rows_r <= cfg_wdata;
        REG_GRID_COLS: grid_cols_r <= cfg_wdata;
      endcase
    end
  end

  assign pend      = upd && ctl.emit;
  assign room_sum  = {1'b0, fill} + (FW+1)'(pend);
  assign in_tready = room_sum < (FW+1)'(OQ_DEPTH);
  assign accept    = in_tvalid && in_tready;

  ncnt_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .grid_rows (grid_rows_r),
    .grid_cols (grid_cols_r),
    .accept    (accept),
    .in_mode   (in_tuser),
    .in_mine   (in_tdata[0]),
    .rd_go     (rd_go),
    .rd_addr   (rd_addr),
    .upd_r     (upd),
    .addr_r    (addr),
    .ctl_r     (ctl)
  );

  ncnt_ram #(
    .WIDTH (2),
    .DEPTH (MAX_COLS)
  ) u_line (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  ncnt_window #(
    .MAX_COLS (MAX_COLS)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (upd),
    .addr    (addr),
    .ctl     (ctl),
    .rd_go   (rd_go),
    .rd_addr (rd_addr),
    .rdata   (rdata),
    .we_o    (we),
    .wdata   (wdata),
    .push    (push),
    .res     (push_res)
  );

  ncnt_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_res   (push_res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_res    (out_res),
    .fill       (fill)
  );

  assign out_tdata = {out_res.col, out_res.row, out_res.count};
  assign out_tlast = out_res.last;

  `NCNT_AST_IMP(a_room, 1'b1, room_sum <= (FW+1)'(OQ_DEPTH), "results in flight exceed queue")

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ncnt_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  ncnt_reg_t         cfg_addr;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;   // mine
  logic              in_tuser;   // mode
  logic              out_tvalid;
  logic              out_tready;
  logic [15:0]       out_tdata;  // count, out_row, out_col
  logic              out_tlast;

  neighbor_count_3x3 uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  localparam bit MODE_CELL  = 1'b0;
  localparam bit MODE_FLUSH = 1'b1;

  ncnt_res_t   expected_counts[$];
  int          errors = 0;
  int          cells_sent = 0;
  bit          tx_idle = 1'b0;
  bit          rx_idle = 1'b0;
  int          rx_long_hold = 0;

  // predictor state
  logic [CFG_W-1:0] rows_reg;
  logic [CFG_W-1:0] cols_reg;
  bit               older_line[MAX_COLS_DEF];
  bit               recent_line[MAX_COLS_DEF];
  logic [8:0]       win_bits;
  int unsigned      row_pos;
  int unsigned      col_pos;
  bit               grid_done;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic int unsigned dim_of(logic [CFG_W-1:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic void step_position(int unsigned w);
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      if (row_pos < 127) row_pos++;
    end
  endfunction

  function automatic void reset_counter_model();
    rows_reg = GRID_DIM_RST;
    cols_reg = GRID_DIM_RST;
    foreach (older_line[i]) begin
      older_line[i] = 1'b0;
      recent_line[i] = 1'b0;
    end
    win_bits = '0;
    row_pos = 0;
    col_pos = 0;
    grid_done = 1'b0;
  endfunction

  function automatic void predict_neighbor_count(bit mode, bit mine);
    int unsigned rows, w, total, p, q, rq, cq, cnt;
    bit          b;
    logic [2:0]  colv, cb;
    logic [8:0]  oldwin, src;
    ncnt_res_t   res;
    rows = dim_of(rows_reg, MAX_ROWS_DEF);
    w = dim_of(cols_reg, MAX_COLS_DEF);
    if (grid_done) begin
      if (mode == MODE_FLUSH) return;
      grid_done = 1'b0;
      row_pos = 0;
      col_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      if (row_pos < 127) row_pos++;
    end
    total = rows * w;
    p = row_pos * w + col_pos;
    if (p > total + w) begin
      grid_done = 1'b1;
      return;
    end
    b = (mode == MODE_CELL && p < total) ? mine : 1'b0;
    colv = {b, recent_line[col_pos], older_line[col_pos]};
    older_line[col_pos] = recent_line[col_pos];
    recent_line[col_pos] = b;
    oldwin = win_bits;
    win_bits = {win_bits[5:0], colv};
    if (p < w + 1) begin
      step_position(w);
      return;
    end
    q = p - w - 1;
    rq = q / w;
    cq = q % w;
    // slot k holds column cq+1-k, rows top/mid/bottom in bits 0/1/2
    src = (col_pos >= 1) ? win_bits : {oldwin[5:0], 3'b000};
    cnt = 0;
    for (int k = 0; k < 3; k++) begin
      if (cq + 1 < k || cq + 1 - k >= w) continue;
      cb = src[3*k +: 3];
      if (rq >= 1) cnt += cb[0];
      cnt += cb[1];
      if (rq + 1 < rows) cnt += cb[2];
    end
    res.count = cnt[CNT_W-1:0];
    res.row   = rq[POS_W-1:0];
    res.col   = cq[POS_W-1:0];
    res.last  = (q == total - 1);
    expected_counts.push_back(res);
    if (q == total - 1) grid_done = 1'b1;
    else step_position(w);
  endfunction

  // all driving tasks start and end at a falling edge
  task automatic send_cell(bit mode, bit mine);
    int gap;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = mode;
    in_tdata  = {7'd0, mine};
    do @(posedge clk); while (!in_tready);
    predict_neighbor_count(mode, mine);
    cells_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_dim(ncnt_reg_t addr, logic [CFG_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (addr == REG_GRID_ROWS) rows_reg = val;
    else cols_reg = val;
  endtask

  task automatic wait_results_done();
    while (expected_counts.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic finish_grid();
    while (!grid_done) send_cell(MODE_FLUSH, 1'($urandom_range(0, 1)));
  endtask

  task automatic set_grid(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
    wait_results_done();
    write_dim(REG_GRID_ROWS, rows);
    write_dim(REG_GRID_COLS, cols);
  endtask

  task automatic run_random_grid(int dens, bit noisy);
    int unsigned n;
    n = dim_of(rows_reg, MAX_ROWS_DEF) * dim_of(cols_reg, MAX_COLS_DEF);
    for (int unsigned i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 39) == 0)
        send_cell(MODE_FLUSH, 1'($urandom_range(0, 1)));
      else send_cell(MODE_CELL, $urandom_range(0, 3) < dens);
    end
    // drain with flushes and cells past the end
    while (!grid_done) begin
      if (noisy && $urandom_range(0, 3) == 0) send_cell(MODE_CELL, 1'($urandom_range(0, 1)));
      else send_cell(MODE_FLUSH, 1'($urandom_range(0, 1)));
    end
    if (noisy && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_cell(MODE_FLUSH, 1'($urandom_range(0, 1)));
  endtask

  // first grid at the reset dimensions
  task automatic test_reset_dims();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    run_random_grid(2, 1'b0);
  endtask

  // zero register values clamp to one, single-cell grid, extra flushes
  task automatic test_tiny_grids();
    set_grid(7'd0, 7'd0);
    send_cell(MODE_CELL, 1'b1);
    finish_grid();
    send_cell(MODE_FLUSH, 1'b1);
    send_cell(MODE_FLUSH, 1'b0);
    wait_results_done();
    write_dim(REG_GRID_COLS, 7'd2);
    send_cell(MODE_CELL, 1'b1);
    send_cell(MODE_CELL, 1'b0);
    finish_grid();
  endtask

  // all-ones grid reaches count 9, early flush inside the grid, cells past end
  task automatic test_full_and_flush();
    set_grid(7'd3, 7'd3);
    repeat (9) send_cell(MODE_CELL, 1'b1);
    while (!grid_done) send_cell(MODE_CELL, 1'b1);
    send_cell(MODE_CELL, 1'b1);
    send_cell(MODE_FLUSH, 1'b1);
    repeat (7) send_cell(MODE_CELL, 1'b1);
    finish_grid();
  endtask

  // width shrinks mid-grid so the column wraps, then rows shrink past the end
  task automatic test_mid_grid_resize();
    set_grid(7'd4, 7'd3);
    repeat (8) send_cell(MODE_CELL, 1'($urandom_range(0, 1)));
    wait_results_done();
    write_dim(REG_GRID_COLS, 7'd2);
    send_cell(MODE_CELL, 1'b1);
    send_cell(MODE_CELL, 1'b1);
    finish_grid();
    set_grid(7'd4, 7'd3);
    repeat (9) send_cell(MODE_CELL, 1'($urandom_range(0, 1)));
    wait_results_done();
    write_dim(REG_GRID_ROWS, 7'd1);
    send_cell(MODE_CELL, 1'b1);
    send_cell(MODE_FLUSH, 1'b0);
  endtask

  // receiver holds off while the sender streams back to back
  task automatic test_backpressure();
    set_grid(7'd5, 7'd5);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_long_hold = 300;
    run_random_grid(2, 1'b0);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_random_grids();
    int sel;
    while (cells_sent < 1800) begin
      if ($urandom_range(0, 1) == 0) begin
        sel = $urandom_range(0, 19);
        case (sel)
          0, 1: set_grid($urandom_range(0, 1) ? 7'd64 : 7'd127, 7'($urandom_range(1, 2)));
          2, 3: set_grid(7'($urandom_range(1, 2)), $urandom_range(0, 1) ? 7'd64 : 7'd127);
          4: set_grid(7'd0, 7'($urandom_range(0, 8)));
          5: set_grid(7'($urandom_range(0, 8)), 7'd0);
          6: set_grid(7'd64, 7'd3);
          default: set_grid(7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)));
        endcase
      end
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      run_random_grid($urandom_range(0, 4), $urandom_range(0, 3) != 0);
    end
  endtask

  // receiver
  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_long_hold > 0) begin
        out_tready = 1'b0;
        repeat (rx_long_hold) @(negedge clk);
        rx_long_hold = 0;
      end
      stall = rx_idle ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!(rst_n && out_tvalid));
    end
  end

  // result checker
  always @(posedge clk) begin
    ncnt_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_counts.size() == 0) begin
        $display("%0t unexpected beat: tdata %h tlast %b", $time, out_tdata, out_tlast);
        errors++;
      end else begin
        want = expected_counts.pop_front();
        if (out_tdata[3:0] !== want.count) begin
          $display("%0t count mismatch: expected %0d actual %0d", $time, want.count,
                   out_tdata[3:0]);
          errors++;
        end
        if (out_tdata[9:4] !== want.row) begin
          $display("%0t row mismatch: expected %0d actual %0d", $time, want.row,
                   out_tdata[9:4]);
          errors++;
        end
        if (out_tdata[15:10] !== want.col) begin
          $display("%0t col mismatch: expected %0d actual %0d", $time, want.col,
                   out_tdata[15:10]);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t last mismatch: expected %b actual %b", $time, want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    int n;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_GRID_ROWS;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    reset_counter_model();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_dims();
    test_tiny_grids();
    test_full_and_flush();
    test_mid_grid_resize();
    test_backpressure();
    test_random_grids();

    in_tvalid = 1'b0;
    for (n = 0; n < 5000 && expected_counts.size() != 0; n++) @(negedge clk);
    if (expected_counts.size() != 0) begin
      $display("%0t %0d results never arrived: expected %0d actual 0", $time,
               expected_counts.size(), expected_counts.size());
      errors++;
    end
    repeat (10) @(negedge clk);
    if (errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
